// ===== sv/array_deque_macros.svh =====
// ----------------------------------------------------------------------------
// array_deque assertion macros
// shared concurrent assertion forms for the deque blocks
// ----------------------------------------------------------------------------
`ifndef ARRAY_DEQUE_MACROS_SVH
`define ARRAY_DEQUE_MACROS_SVH

// condition holds at every edge out of reset
`define ADQ_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ADQ_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent holds in the cycle after the antecedent
`define ADQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/adq_pkg.sv =====
// ----------------------------------------------------------------------------
// adq_pkg
// types and constants shared by the deque controller and datapath
// ----------------------------------------------------------------------------
package adq_pkg;

   localparam int WORD_W = 32;
   localparam int ACT_W  = 2;
   localparam int STAT_W = 2;
   localparam int OCC_W  = 5;

   typedef enum logic [ACT_W-1:0] {
      ACT_PUSH_FRONT = 2'd0,
      ACT_PUSH_BACK  = 2'd1,
      ACT_POP_FRONT  = 2'd2,
      ACT_POP_BACK   = 2'd3
   } action_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK        = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_UNDERFLOW = 2'd2
   } status_type;

   // what the datapath does with the captured item
   typedef enum logic [2:0] {
      OP_NONE       = 3'd0,
      OP_PUSH_FRONT = 3'd1,
      OP_PUSH_BACK  = 3'd2,
      OP_POP_FRONT  = 3'd3,
      OP_POP_BACK   = 3'd4
   } op_type;

   typedef struct packed {
      logic       exec;
      op_type     op;
      status_type code;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } sts_type;

endpackage

// ===== sv/adq_req_if.sv =====
// ----------------------------------------------------------------------------
// adq_req_if
// request channel: operation code and word to insert
// ----------------------------------------------------------------------------
interface adq_req_if;
   import adq_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [ACT_W-1:0]         action;
   logic signed [WORD_W-1:0] value;

   modport source (output valid, output action, output value, input ready);
   modport sink   (input valid, input action, input value, output ready);

endinterface

// ===== sv/adq_rsp_if.sv =====
// ----------------------------------------------------------------------------
// adq_rsp_if
// response channel: popped word, status and occupancy flags
// ----------------------------------------------------------------------------
interface adq_rsp_if;
   import adq_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [WORD_W-1:0] popped_word;
   logic [STAT_W-1:0]        status;
   logic [OCC_W-1:0]         occupancy;
   logic                     is_full;
   logic                     is_empty;

   modport source (output valid, output popped_word, output status, output occupancy,
                   output is_full, output is_empty, input ready);
   modport sink   (input valid, input popped_word, input status, input occupancy,
                   input is_full, input is_empty, output ready);

endinterface

// ===== sv/array_deque.sv =====
// ----------------------------------------------------------------------------
// array_deque
// double-ended queue of signed words with push and pop at both ends
// ----------------------------------------------------------------------------
// One item is handled at a time. A request is taken when the block is idle;
// the operation runs in that cycle and its response is shown from the next
// cycle. The pace is set by the two-state handshake machine, which takes no
// new request until the response is taken; the word store's read data is
// registered, as are the response fields. Words live in a circular
// store indexed by head and tail pointers, so pushes and pops at either end
// touch one entry only. Full pushes and empty pops are reported as overflow
// or underflow and change nothing. No clearing pass runs after reset.
module array_deque #(
   parameter int DEPTH = 16
) (
   input logic     clock,
   input logic     reset,
   adq_req_if.sink   req_ch,
   adq_rsp_if.source rsp_ch
);
   import adq_pkg::*;

   cmd_type cmd;
   sts_type sts;

   adq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_ch.valid),
      .req_action (req_ch.action),
      .req_ready  (req_ch.ready),
      .rsp_valid  (rsp_ch.valid),
      .rsp_ready  (rsp_ch.ready),
      .sts        (sts),
      .cmd        (cmd)
   );

   adq_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_value   (req_ch.value),
      .sts         (sts),
      .popped_word (rsp_ch.popped_word),
      .status      (rsp_ch.status),
      .occupancy   (rsp_ch.occupancy),
      .is_full     (rsp_ch.is_full),
      .is_empty    (rsp_ch.is_empty)
   );

endmodule

// ===== sv/adq_ctrl.sv =====
// ----------------------------------------------------------------------------
// adq_ctrl
// handshake state machine and operation decode for the deque
// ----------------------------------------------------------------------------
`include "array_deque_macros.svh"

module adq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic [adq_pkg::ACT_W-1:0] req_action,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  adq_pkg::sts_type      sts,
   output adq_pkg::cmd_type      cmd
);
   import adq_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_RESP = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      accept;
   logic      rsp_done;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);
   assign accept    = req_valid && req_ready;
   assign rsp_done  = rsp_valid && rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_done) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   // rejected pushes and pops leave the word store, pointers and count untouched
   always_comb begin
      cmd.exec = accept;
      cmd.op   = OP_NONE;
      cmd.code = ST_OK;
      unique case (action_type'(req_action))
         ACT_PUSH_FRONT: begin
            if (sts.full) cmd.code = ST_OVERFLOW;
            else          cmd.op   = OP_PUSH_FRONT;
         end
         ACT_PUSH_BACK: begin
            if (sts.full) cmd.code = ST_OVERFLOW;
            else          cmd.op   = OP_PUSH_BACK;
         end
         ACT_POP_FRONT: begin
            if (sts.empty) cmd.code = ST_UNDERFLOW;
            else           cmd.op   = OP_POP_FRONT;
         end
         ACT_POP_BACK: begin
            if (sts.empty) cmd.code = ST_UNDERFLOW;
            else           cmd.op   = OP_POP_BACK;
         end
         default: cmd.op = OP_NONE;
      endcase
   end

   `ADQ_ASSERT_NEXT(a_accept_gives_rsp, clock, reset, accept, rsp_valid, "no response after transfer")
   `ADQ_ASSERT_NEXT(a_rsp_done_frees, clock, reset, rsp_done, req_ready, "request side not freed")
   `ADQ_ASSERT_SAME(a_reject_has_code, clock, reset, cmd.exec && cmd.op == OP_NONE, cmd.code != ST_OK, "rejected operation reported ok")

endmodule

// ===== sv/adq_dp.sv =====
// ----------------------------------------------------------------------------
// adq_dp
// circular word store with head, tail and count registers
// ----------------------------------------------------------------------------
`include "array_deque_macros.svh"

module adq_dp #(
   parameter int DEPTH = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  adq_pkg::cmd_type                   cmd,
   input  logic signed [adq_pkg::WORD_W-1:0]  req_value,
   output adq_pkg::sts_type                   sts,
   output logic signed [adq_pkg::WORD_W-1:0]  popped_word,
   output logic [adq_pkg::STAT_W-1:0]         status,
   output logic [adq_pkg::OCC_W-1:0]          occupancy,
   output logic                               is_full,
   output logic                               is_empty
);
   import adq_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   logic [WORD_W-1:0] mem [DEPTH];

   logic [PTR_W-1:0]  head_ff, head_in;   // front word
   logic [PTR_W-1:0]  tail_ff, tail_in;   // next free slot at the back
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [WORD_W-1:0] rd_data_ff;
   logic              pop_ok_ff;
   status_type        code_ff;

   logic              wr_en, rd_en;
   logic [PTR_W-1:0]  wr_addr, rd_addr;
   logic [PTR_W-1:0]  head_dec, head_inc, tail_dec, tail_inc;
   logic [CNT_W+OCC_W-1:0] occ_wide;

   // wrap at DEPTH, which need not be a power of two
   assign head_inc = (head_ff == PTR_LAST) ? '0 : head_ff + 1'b1;
   assign head_dec = (head_ff == '0) ? PTR_LAST : head_ff - 1'b1;
   assign tail_inc = (tail_ff == PTR_LAST) ? '0 : tail_ff + 1'b1;
   assign tail_dec = (tail_ff == '0) ? PTR_LAST : tail_ff - 1'b1;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      wr_en    = 1'b0;
      rd_en    = 1'b0;
      wr_addr  = tail_ff;
      rd_addr  = head_ff;
      if (cmd.exec) begin
         unique case (cmd.op)
            OP_NONE: begin
               head_in = head_ff;
            end
            OP_PUSH_FRONT: begin
               head_in  = head_dec;
               wr_en    = 1'b1;
               wr_addr  = head_dec;
               count_in = count_ff + 1'b1;
            end
            OP_PUSH_BACK: begin
               tail_in  = tail_inc;
               wr_en    = 1'b1;
               wr_addr  = tail_ff;
               count_in = count_ff + 1'b1;
            end
            OP_POP_FRONT: begin
               head_in  = head_inc;
               rd_en    = 1'b1;
               rd_addr  = head_ff;
               count_in = count_ff - 1'b1;
            end
            OP_POP_BACK: begin
               tail_in  = tail_dec;
               rd_en    = 1'b1;
               rd_addr  = tail_dec;
               count_in = count_ff - 1'b1;
            end
            default: head_in = head_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= req_value;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         pop_ok_ff <= rd_en;
         code_ff   <= cmd.code;
      end
   end

   assign sts.full    = (count_ff == CNT_FULL);
   assign sts.empty   = (count_ff == '0);
   assign is_full     = sts.full;
   assign is_empty    = sts.empty;
   assign popped_word = pop_ok_ff ? signed'(rd_data_ff) : '0;
   assign status      = code_ff;
   assign occ_wide    = (CNT_W + OCC_W)'(count_ff);
   assign occupancy   = occ_wide[OCC_W-1:0];

   `ADQ_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CNT_FULL, "count above depth")
   `ADQ_ASSERT_NEXT(a_reject_holds, clock, reset, cmd.exec && cmd.op == OP_NONE, $stable(count_ff) && $stable(head_ff) && $stable(tail_ff), "rejected operation changed state")
   `ADQ_ASSERT_NEXT(a_push_counts, clock, reset, cmd.exec && (cmd.op == OP_PUSH_FRONT || cmd.op == OP_PUSH_BACK), count_ff == $past(count_ff) + 1'b1, "push did not add one")

endmodule

// ===== tb/array_deque_tb.sv =====
// ----------------------------------------------------------------------------
// array_deque_tb
// self-checking bench for the double-ended queue: a directed table covering
// empty pops, full pushes and the word extremes, then biased random traffic
// that swings the queue between empty and full under varied backpressure.
// every response is compared with a queue-based mirror of the deque, or with the row's hand-written expectation.
// ----------------------------------------------------------------------------
module array_deque_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import adq_pkg::*;

   localparam int QDEPTH      = 16;
   localparam int RANDOM_OPS  = 1600;
   localparam int PHASE_COUNT = 4;
   localparam int LONG_HOLD   = 200;
   localparam int TAIL_CYCLES = 20;

   typedef struct packed {
      logic signed [WORD_W-1:0] word;
      status_type               status;
      logic [OCC_W-1:0]         occ;
      logic                     full;
      logic                     empty;
   } deque_reply_type;

   typedef struct packed {
      action_type         act;
      logic [WORD_W-1:0]  value;
      logic [4:0]         reps;
      logic               typed;
      deque_reply_type    want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   adq_req_if req_ch ();
   adq_rsp_if rsp_ch ();

   array_deque #(.DEPTH(QDEPTH)) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // mirror of the held words, front at index 0
   logic signed [WORD_W-1:0] mirror_words [$];
   deque_reply_type          expected_replies [$];

   // hand-written expectation travelling with the item on the request side
   logic            req_typed;
   deque_reply_type req_typed_reply;

   int send_idle_pct   = 0;
   int rsp_stall_pct   = 0;
   int hold_cycles_req = 0;
   int fail_count      = 0;

   // values after the first transfer of a row step up by one per repeat
   stim_row_type directed_rows [0:11] = '{
      '{ACT_POP_FRONT,  32'h0000_0000, 5'd1, 1'b1, '{32'sh0, ST_UNDERFLOW, 5'd0, 1'b0, 1'b1}},
      '{ACT_POP_BACK,   32'hFFFF_FFFF, 5'd1, 1'b1, '{32'sh0, ST_UNDERFLOW, 5'd0, 1'b0, 1'b1}},
      '{ACT_PUSH_BACK,  32'h7FFF_FFFF, 5'd1, 1'b1, '{32'sh0, ST_OK, 5'd1, 1'b0, 1'b0}},
      '{ACT_PUSH_FRONT, 32'h8000_0000, 5'd1, 1'b1, '{32'sh0, ST_OK, 5'd2, 1'b0, 1'b0}},
      '{ACT_POP_BACK,   32'h0000_0000, 5'd1, 1'b1,
        '{32'sh7FFF_FFFF, ST_OK, 5'd1, 1'b0, 1'b0}},
      '{ACT_POP_FRONT,  32'hFFFF_FFFF, 5'd1, 1'b1,
        '{32'sh8000_0000, ST_OK, 5'd0, 1'b0, 1'b1}},
      '{ACT_PUSH_FRONT, 32'hFFFF_FFF8, 5'd8, 1'b0, '0},
      '{ACT_PUSH_BACK,  32'h5555_5555, 5'd8, 1'b0, '0},
      '{ACT_PUSH_BACK,  32'h0000_0001, 5'd1, 1'b1, '{32'sh0, ST_OVERFLOW, 5'd16, 1'b1, 1'b0}},
      '{ACT_PUSH_FRONT, 32'h0000_0002, 5'd1, 1'b1, '{32'sh0, ST_OVERFLOW, 5'd16, 1'b1, 1'b0}},
      '{ACT_POP_FRONT,  32'h0000_0000, 5'd1, 1'b0, '0},
      '{ACT_PUSH_BACK,  32'hAAAA_AAAA, 5'd1, 1'b0, '0}
   };

   function automatic deque_reply_type deque_apply(action_type act,
                                                   logic signed [WORD_W-1:0] word);
      deque_reply_type r;
      r = '0;
      r.status = ST_OK;
      case (act)
         ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
            if (mirror_words.size() >= QDEPTH)
               r.status = ST_OVERFLOW;
            else if (act == ACT_PUSH_FRONT)
               mirror_words.push_front(word);
            else
               mirror_words.push_back(word);
         end
         ACT_POP_FRONT: begin
            if (mirror_words.size() == 0)
               r.status = ST_UNDERFLOW;
            else
               r.word = mirror_words.pop_front();
         end
         default: begin
            if (mirror_words.size() == 0)
               r.status = ST_UNDERFLOW;
            else
               r.word = mirror_words.pop_back();
         end
      endcase
      r.occ   = OCC_W'(mirror_words.size());
      r.full  = (mirror_words.size() == QDEPTH);
      r.empty = (mirror_words.size() == 0);
      return r;
   endfunction

   function automatic void note_fault(string msg);
      fail_count++;
      if (fail_count <= 10)
         $display("%0t: %s", $realtime, msg);
   endfunction

   function automatic string reply_text(deque_reply_type r);
      return $sformatf("word %0d status %0d occ %0d full %b empty %b",
                       r.word, r.status, r.occ, r.full, r.empty);
   endfunction

   // both channels sampled at the edge, before the bench's own updates land
   always @(posedge clock) begin
      deque_reply_type want;
      deque_reply_type got;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.word   = rsp_ch.popped_word;
            got.status = status_type'(rsp_ch.status);
            got.occ    = rsp_ch.occupancy;
            got.full   = rsp_ch.is_full;
            got.empty  = rsp_ch.is_empty;
            if (expected_replies.size() == 0) begin
               note_fault({"response with nothing expected: ", reply_text(got)});
            end else begin
               want = expected_replies.pop_front();
               if (got.word !== want.word || got.status !== want.status ||
                   got.occ !== want.occ || got.full !== want.full ||
                   got.empty !== want.empty)
                  note_fault({"mismatch: expected ", reply_text(want),
                              " | got ", reply_text(got)});
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            want = deque_apply(action_type'(req_ch.action), req_ch.value);
            if (req_typed)
               want = req_typed_reply;
            expected_replies.push_back(want);
         end
      end
   end

   // response side: random stalls, plus a long hold-off on request
   initial begin
      int n;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_cycles_req > 0) begin
            n = hold_cycles_req;
            hold_cycles_req = 0;
            rsp_ch.ready <= 1'b0;
            repeat (n) @(posedge clock);
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   task automatic send_item(input action_type act, input logic [WORD_W-1:0] word,
                            input logic typed, input deque_reply_type want);
      int gap;
      req_ch.valid    <= 1'b1;
      req_ch.action   <= act;
      req_ch.value    <= word;
      req_typed       <= typed;
      req_typed_reply <= want;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      gap = 0;
      while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_replies();
      @(posedge clock);
      while (expected_replies.size() != 0) @(posedge clock);
   endtask

   function automatic logic [WORD_W-1:0] pick_word();
      case ($urandom_range(9))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   initial begin
      int push_pct;
      action_type act;
      req_ch.valid    = 1'b0;
      req_ch.action   = ACT_PUSH_FRONT;
      req_ch.value    = '0;
      req_typed       = 1'b0;
      req_typed_reply = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         for (int k = 0; k < directed_rows[i].reps; k++)
            send_item(directed_rows[i].act, directed_rows[i].value + k,
                      directed_rows[i].typed, directed_rows[i].want);
      end
      req_ch.valid <= 1'b0;
      drain_replies();

      push_pct = 50;
      for (int p = 0; p < PHASE_COUNT; p++) begin
         case (p)
            0:       begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1:       begin send_idle_pct = 66; rsp_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  rsp_stall_pct = 66; end
            default: begin send_idle_pct = 33; rsp_stall_pct = 33; end
         endcase
         // the block holds one item, so the sender backs up during this hold
         if (p == 2)
            hold_cycles_req = LONG_HOLD;
         for (int k = 0; k < RANDOM_OPS / PHASE_COUNT; k++) begin
            // drift between filling and draining so both ends get hit often
            if (k % 40 == 0) begin
               case ($urandom_range(2))
                  0:       push_pct = 15;
                  1:       push_pct = 50;
                  default: push_pct = 85;
               endcase
            end
            if ($urandom_range(99) < push_pct)
               act = $urandom_range(1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
            else
               act = $urandom_range(1) ? ACT_POP_BACK : ACT_POP_FRONT;
            send_item(act, pick_word(), 1'b0, '0);
         end
         req_ch.valid <= 1'b0;
         drain_replies();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_replies.size() != 0)
         note_fault("responses still outstanding at end of run");
      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
